// ===== sv/adsr_pkg.sv =====
// shared types and constants for the adsr envelope generator
package adsr_pkg;

    localparam int LEVEL_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int TERM_W    = 18;

    localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_TARGET_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_HOLD_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETRIGGER_CLEARS  = 3'd5;

    localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP       = 17'h10000;
    localparam logic [LEVEL_W-1:0] RST_DECAY_TARGET_GAIN = 17'h10000;
    localparam logic [GAIN_W-1:0]  RST_DECAY_HOLD_GAIN   = 16'h0000;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL     = 17'h08000;
    localparam logic [GAIN_W-1:0]  RST_RELEASE_GAIN      = 16'h0000;

    typedef enum logic [1:0] {
        STAGE_ATTACK  = 2'd0,
        STAGE_DECAY   = 2'd1,
        STAGE_RELEASE = 2'd2
    } stage_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [GAIN_W-1:0]  decay_hold_gain;
        logic [GAIN_W-1:0]  release_gain;
        logic               retrigger_clears;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  last_trigger;
        logic [BYTE_W-1:0]  last_gate;
        stage_t             stage;
        logic [LEVEL_W-1:0] level;
    } env_state_t;

endpackage

// ===== sv/adsr_envelope_generator_core.sv =====
// adsr envelope generator top level: config registers, input and result registers
// accepted input word: input register, then envelope state and result register
// throughput: one word per cycle unless m_ready stalls; combinational update loop
// the sustain term is a product of two config registers, formed in the update cycle
// reset: aresetn synchronous active low; config to defaults, stage release, level zero
// both pipeline registers empty after reset; no clearing pass
module adsr_envelope_generator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [adsr_pkg::BYTE_W-1:0]      s_trigger_value,
    input  logic [adsr_pkg::BYTE_W-1:0]      s_gate_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]     m_envelope_level,
    input  logic                             cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [adsr_pkg::CFG_W-1:0]       cfg_wdata
);

    logic [adsr_pkg::LEVEL_W-1:0] attack_step_reg;
    logic [adsr_pkg::LEVEL_W-1:0] decay_target_gain_reg;
    logic [adsr_pkg::GAIN_W-1:0]  decay_hold_gain_reg;
    logic [adsr_pkg::LEVEL_W-1:0] sustain_level_reg;
    logic [adsr_pkg::GAIN_W-1:0]  release_gain_reg;
    logic                         retrigger_clears_reg;

    logic [33:0]                  sustain_prod;
    logic [adsr_pkg::TERM_W-1:0]  sustain_term;

    logic                         in_valid_reg;
    logic [adsr_pkg::BYTE_W-1:0]  in_trigger_reg;
    logic [adsr_pkg::BYTE_W-1:0]  in_gate_reg;

    logic                         out_valid_reg;
    logic [adsr_pkg::LEVEL_W-1:0] out_level_reg;

    adsr_pkg::env_state_t         state_reg;
    adsr_pkg::env_state_t         state_next;
    adsr_pkg::cfg_t               cfg;
    logic                         advance;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_step_reg       <= adsr_pkg::RST_ATTACK_STEP;
            decay_target_gain_reg <= adsr_pkg::RST_DECAY_TARGET_GAIN;
            decay_hold_gain_reg   <= adsr_pkg::RST_DECAY_HOLD_GAIN;
            sustain_level_reg     <= adsr_pkg::RST_SUSTAIN_LEVEL;
            release_gain_reg      <= adsr_pkg::RST_RELEASE_GAIN;
            retrigger_clears_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                adsr_pkg::REG_ATTACK_STEP:       attack_step_reg       <= cfg_wdata;
                adsr_pkg::REG_DECAY_TARGET_GAIN: decay_target_gain_reg <= cfg_wdata;
                adsr_pkg::REG_DECAY_HOLD_GAIN: begin
                    decay_hold_gain_reg <= cfg_wdata[adsr_pkg::GAIN_W-1:0];
                end
                adsr_pkg::REG_SUSTAIN_LEVEL:     sustain_level_reg     <= cfg_wdata;
                adsr_pkg::REG_RELEASE_GAIN: begin
                    release_gain_reg <= cfg_wdata[adsr_pkg::GAIN_W-1:0];
                end
                adsr_pkg::REG_RETRIGGER_CLEARS:  retrigger_clears_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign sustain_prod = 34'(sustain_level_reg) * 34'(decay_target_gain_reg);
    assign sustain_term = sustain_prod[33:16];

    assign cfg.attack_step      = attack_step_reg;
    assign cfg.decay_hold_gain  = decay_hold_gain_reg;
    assign cfg.release_gain     = release_gain_reg;
    assign cfg.retrigger_clears = retrigger_clears_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_trigger_reg <= s_trigger_value;
            in_gate_reg    <= s_gate_value;
        end
    end

    adsr_step u_step (
        .trigger_value (in_trigger_reg),
        .gate_value    (in_gate_reg),
        .state_cur     (state_reg),
        .cfg           (cfg),
        .sustain_term  (sustain_term),
        .state_new     (state_next)
    );

    // envelope state and result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.last_trigger <= '0;
            state_reg.last_gate    <= '0;
            state_reg.stage        <= adsr_pkg::STAGE_RELEASE;
            state_reg.level        <= '0;
            out_valid_reg          <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_level_reg <= state_next.level;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_envelope_level = out_level_reg;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.level <= adsr_pkg::ONE_Q16)
        else $error("envelope level above one");

    a_out_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_envelope_level <= adsr_pkg::ONE_Q16))
        else $error("result word above one");

    a_out_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_valid && (m_envelope_level == state_reg.level)))
        else $error("result word differs from envelope state");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_idle_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("envelope state moved without a word");

endmodule

// ===== sv/adsr_step.sv =====
// one envelope tick: trigger and gate handling, then attack, decay or release update
module adsr_step (
    input  logic [adsr_pkg::BYTE_W-1:0] trigger_value,
    input  logic [adsr_pkg::BYTE_W-1:0] gate_value,
    input  adsr_pkg::env_state_t        state_cur,
    input  adsr_pkg::cfg_t              cfg,
    input  logic [adsr_pkg::TERM_W-1:0] sustain_term,
    output adsr_pkg::env_state_t        state_new
);

    logic                          trig_change;
    logic                          gate_fall;
    adsr_pkg::stage_t              stage_pre;
    logic [adsr_pkg::LEVEL_W-1:0]  level_pre;
    logic [adsr_pkg::LEVEL_W:0]    attack_sum;
    logic [32:0]                   hold_prod;
    logic [18:0]                   decay_sum;
    logic [32:0]                   release_prod;

    assign trig_change = (trigger_value != state_cur.last_trigger);
    assign gate_fall   = (gate_value != state_cur.last_gate) && (gate_value == '0);

    always_comb begin
        if (gate_fall) begin
            stage_pre = adsr_pkg::STAGE_RELEASE;
        end else if (trig_change) begin
            stage_pre = adsr_pkg::STAGE_ATTACK;
        end else begin
            stage_pre = state_cur.stage;
        end
        level_pre = (trig_change && cfg.retrigger_clears) ? '0 : state_cur.level;
    end

    assign attack_sum   = {1'b0, level_pre} + {1'b0, cfg.attack_step};
    assign hold_prod    = 33'(level_pre) * 33'(cfg.decay_hold_gain);
    assign decay_sum    = 19'(sustain_term) + 19'(hold_prod[32:16]);
    assign release_prod = 33'(level_pre) * 33'(cfg.release_gain);

    always_comb begin
        state_new.last_trigger = trigger_value;
        state_new.last_gate    = gate_value;
        state_new.stage        = stage_pre;
        state_new.level        = level_pre;
        case (stage_pre)
            adsr_pkg::STAGE_ATTACK: begin
                if (attack_sum > 18'(adsr_pkg::ONE_Q16)) begin
                    state_new.level = adsr_pkg::ONE_Q16;
                    state_new.stage = adsr_pkg::STAGE_DECAY;
                end else begin
                    state_new.level = attack_sum[adsr_pkg::LEVEL_W-1:0];
                end
            end
            adsr_pkg::STAGE_DECAY: begin
                if (decay_sum > 19'(adsr_pkg::ONE_Q16)) begin
                    state_new.level = adsr_pkg::ONE_Q16;
                end else begin
                    state_new.level = decay_sum[adsr_pkg::LEVEL_W-1:0];
                end
            end
            adsr_pkg::STAGE_RELEASE: begin
                state_new.level = release_prod[32:16];
            end
            default: begin
                state_new.level = level_pre;
            end
        endcase
    end

endmodule
